// File: hw/rtl/amrm_pkg.sv
// ----------------------------------------------------------------------------
// amrm_pkg
// Shared types and constants of the ambisonic render matrix mixer: field
// widths, register map, configuration bundle, queued operations and results.
// ----------------------------------------------------------------------------
`default_nettype none

package amrm_pkg;

    localparam int MAX_COMPONENTS_DEF      = 64;
    localparam int MAX_OUTPUT_CHANNELS_DEF = 32;
    localparam int QUEUE_DEPTH             = 4;

    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = 56;
    localparam int RND_SHIFT = 20;
    localparam int RND_W    = ACC_W - RND_SHIFT;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_ORDER      = 3'd0;
    localparam logic [2:0] REG_CHAN_COUNT = 3'd1;
    localparam logic [2:0] REG_CLIP_EN    = 3'd2;
    localparam logic [2:0] REG_CLIP_UPPER = 3'd3;
    localparam logic [2:0] REG_CLIP_LOWER = 3'd4;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        OP_COEF,
        OP_SAMPLE,
        OP_RENDER
    } op_kind_t;

    typedef struct packed {
        logic [CNT_W-1:0]        comp_count;
        logic [CNT_W-1:0]        chan_count;
        logic                    clip_en;
        logic signed [OUT_W-1:0] clip_upper;
        logic signed [OUT_W-1:0] clip_lower;
    } cfg_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic [IDX_W-1:0]           spk;
        logic [IDX_W-1:0]           comp;
        logic signed [COEF_W-1:0]   data;
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0]        channel;
        logic signed [OUT_W-1:0] sample;
        logic                    clipped;
        logic                    last;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ambisonic_render_matrix_mixer.sv
// ----------------------------------------------------------------------------
// ambisonic_render_matrix_mixer
// Higher-order ambisonic to loudspeaker renderer: coefficient writes and
// component samples in, one clipped Q8.23 dot product per channel out.
// ----------------------------------------------------------------------------
// Items enter a four-deep operation queue at one per cycle while it has
// room. The back end retires a coefficient write or a sample store without
// leaving its idle state. The item carrying the last component of an instant
// triggers the render: each output channel is computed by the single
// multiply-accumulate unit reading one coefficient and one sample per cycle
// from the coefficient memory and component buffer, followed by rounding,
// saturation and clipping stages. Results wait in a four-deep result queue;
// the back end stalls when it is full. Memories have no reset: a sample or
// coefficient read before it is written gives an undefined result.
// ----------------------------------------------------------------------------
`default_nettype none

module ambisonic_render_matrix_mixer
    import amrm_pkg::*;
#(
    parameter int MAX_COMPONENTS      = MAX_COMPONENTS_DEF,
    parameter int MAX_OUTPUT_CHANNELS = MAX_OUTPUT_CHANNELS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic      [APB_DATA_W-1:0]      prdata,
    output logic                            pready,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       command,
    input  wire logic [IDX_W-1:0]           speaker_index,
    input  wire logic [IDX_W-1:0]           component_index,
    input  wire logic signed [COEF_W-1:0]   coefficient_value,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [IDX_W-1:0]                output_channel,
    output logic signed [OUT_W-1:0]         output_sample,
    output logic                            was_clipped,
    output logic                            last_channel
);

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(res_t);

    cfg_t             cfg;
    op_t              op_in;
    op_t              op_out;
    res_t             res_in;
    res_t             res_out;
    logic [OP_W-1:0]  op_q_rd;
    logic [RES_W-1:0] res_q_rd;
    logic             op_push;
    logic             op_full;
    logic             op_pop;
    logic             op_empty;
    logic             res_push;
    logic             res_full;

    amrm_regs #(
        .MAX_COMPONENTS      (MAX_COMPONENTS),
        .MAX_OUTPUT_CHANNELS (MAX_OUTPUT_CHANNELS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    amrm_front #(
        .MAX_COMPONENTS      (MAX_COMPONENTS),
        .MAX_OUTPUT_CHANNELS (MAX_OUTPUT_CHANNELS)
    ) u_front (
        .push              (push),
        .full              (full),
        .command           (command),
        .speaker_index     (speaker_index),
        .component_index   (component_index),
        .coefficient_value (coefficient_value),
        .sample_value      (sample_value),
        .cfg               (cfg),
        .op_full           (op_full),
        .op_push           (op_push),
        .op                (op_in)
    );

    amrm_queue #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (op_q_rd),
        .empty   (op_empty)
    );

    assign op_out = op_t'(op_q_rd);

    amrm_back #(
        .MAX_COMPONENTS      (MAX_COMPONENTS),
        .MAX_OUTPUT_CHANNELS (MAX_OUTPUT_CHANNELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    amrm_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q_rd),
        .empty   (empty)
    );

    assign res_out        = res_t'(res_q_rd);
    assign output_channel = res_out.channel;
    assign output_sample  = res_out.sample;
    assign was_clipped    = res_out.clipped;
    assign last_channel   = res_out.last;

`ifndef SYNTHESIS
    a_res_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full result queue");

    a_op_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> !op_empty)
        else $error("operation taken from an empty queue");

    a_op_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> (push && !full))
        else $error("operation queued without an input transfer");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(output_channel) < MAX_OUTPUT_CHANNELS))
        else $error("result channel beyond the channel limit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/amrm_regs.sv
// ----------------------------------------------------------------------------
// amrm_regs
// APB-style configuration registers and the derived component and channel
// counts used by the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module amrm_regs
    import amrm_pkg::*;
#(
    parameter int MAX_COMPONENTS      = MAX_COMPONENTS_DEF,
    parameter int MAX_OUTPUT_CHANNELS = MAX_OUTPUT_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [2:0]              order_reg;
    logic [CNT_W-1:0]        chan_count_reg;
    logic                    clip_en_reg;
    logic signed [OUT_W-1:0] clip_upper_reg;
    logic signed [OUT_W-1:0] clip_lower_reg;

    logic       wr_en;
    logic [2:0] reg_idx;
    logic [3:0] order_p1;
    logic [7:0] comp_sq;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= 3'd0;
            chan_count_reg <= CNT_W'(1);
            clip_en_reg    <= 1'b0;
            clip_upper_reg <= 32'sd8388607;
            clip_lower_reg <= -32'sd8388608;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ORDER:      order_reg      <= pwdata[2:0];
                REG_CHAN_COUNT: chan_count_reg <= pwdata[CNT_W-1:0];
                REG_CLIP_EN:    clip_en_reg    <= pwdata[0];
                REG_CLIP_UPPER: clip_upper_reg <= pwdata[OUT_W-1:0];
                REG_CLIP_LOWER: clip_lower_reg <= pwdata[OUT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_ORDER:      prdata = {29'd0, order_reg};
            REG_CHAN_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, chan_count_reg};
            REG_CLIP_EN:    prdata = {31'd0, clip_en_reg};
            REG_CLIP_UPPER: prdata = clip_upper_reg;
            REG_CLIP_LOWER: prdata = clip_lower_reg;
            default:        prdata = '0;
        endcase
    end

    assign order_p1 = {1'b0, order_reg} + 4'd1;
    assign comp_sq  = 8'(order_p1 * order_p1);

    always_comb
    begin
        if (32'(comp_sq) > MAX_COMPONENTS)
            cfg.comp_count = CNT_W'(MAX_COMPONENTS);
        else
            cfg.comp_count = comp_sq[CNT_W-1:0];

        if (chan_count_reg == '0)
            cfg.chan_count = CNT_W'(1);
        else if (32'(chan_count_reg) > MAX_OUTPUT_CHANNELS)
            cfg.chan_count = CNT_W'(MAX_OUTPUT_CHANNELS);
        else
            cfg.chan_count = chan_count_reg;

        cfg.clip_en    = clip_en_reg;
        cfg.clip_upper = clip_upper_reg;
        cfg.clip_lower = clip_lower_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/amrm_front.sv
// ----------------------------------------------------------------------------
// amrm_front
// Input side: accepts items, drops out-of-range writes and classifies the
// rest as coefficient write, sample store or sample store with render.
// ----------------------------------------------------------------------------
`default_nettype none

module amrm_front
    import amrm_pkg::*;
#(
    parameter int MAX_COMPONENTS      = MAX_COMPONENTS_DEF,
    parameter int MAX_OUTPUT_CHANNELS = MAX_OUTPUT_CHANNELS_DEF
)
(
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       command,
    input  wire logic [IDX_W-1:0]           speaker_index,
    input  wire logic [IDX_W-1:0]           component_index,
    input  wire logic signed [COEF_W-1:0]   coefficient_value,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  cfg_t                            cfg,
    input  wire logic                       op_full,
    output logic                            op_push,
    output op_t                             op
);

    logic accept;
    logic comp_ok;
    logic spk_ok;
    logic is_last;

    assign full    = op_full;
    assign accept  = push && !op_full;
    assign comp_ok = 32'(component_index) < MAX_COMPONENTS;
    assign spk_ok  = 32'(speaker_index) < MAX_OUTPUT_CHANNELS;
    assign is_last = {1'b0, component_index} == (cfg.comp_count - CNT_W'(1));

    assign op_push = accept && comp_ok && (command == CMD_SAMPLE || spk_ok);

    always_comb
    begin
        op.spk  = speaker_index;
        op.comp = component_index;
        if (command == CMD_COEF)
        begin
            op.kind = OP_COEF;
            op.data = coefficient_value;
        end
        else
        begin
            op.kind = is_last ? OP_RENDER : OP_SAMPLE;
            op.data = sample_value;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/amrm_queue.sv
// ----------------------------------------------------------------------------
// amrm_queue
// Small synchronous FIFO that decouples the front end, the back end and the
// result consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module amrm_queue
    import amrm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = count_reg == COUNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + COUNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - COUNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/amrm_back.sv
// ----------------------------------------------------------------------------
// amrm_back
// Execution side: holds the coefficient memory and component buffer, runs
// one multiply-accumulate per cycle per channel, then rounds, saturates and
// clips each dot product into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module amrm_back
    import amrm_pkg::*;
#(
    parameter int MAX_COMPONENTS      = MAX_COMPONENTS_DEF,
    parameter int MAX_OUTPUT_CHANNELS = MAX_OUTPUT_CHANNELS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic op_empty,
    input  op_t       op,
    output logic      op_pop,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res
);

    localparam int COEF_DEPTH = MAX_OUTPUT_CHANNELS * MAX_COMPONENTS;
    localparam int CADDR_W    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int BADDR_W    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [RND_W-1:0] RND_MAX =
        {{(RND_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [RND_W-1:0] RND_MIN =
        {{(RND_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ROUND,
        S_SAT,
        S_EMIT
    } state_t;

    logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
    logic signed [SAMPLE_W-1:0] buf_mem  [MAX_COMPONENTS];

    state_t                     state_reg;
    logic [CNT_W-1:0]           k_reg;
    logic [IDX_W-1:0]           ch_reg;
    logic [CADDR_W-1:0]         row_base_reg;
    logic                       rd_valid_reg;
    logic                       prod_valid_reg;
    logic signed [COEF_W-1:0]   coef_rd_reg;
    logic signed [SAMPLE_W-1:0] buf_rd_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [RND_W-1:0]    rnd_reg;
    logic signed [OUT_W-1:0]    sat_reg;

    logic                       take;
    logic                       coef_we;
    logic                       buf_we;
    logic                       issuing;
    logic                       last_ch;
    logic [CADDR_W-1:0]         coef_wa;
    logic [CADDR_W-1:0]         coef_ra;
    logic [BADDR_W-1:0]         buf_wa;
    logic [BADDR_W-1:0]         buf_ra;
    logic signed [ACC_W-1:0]    acc_biased;
    logic signed [OUT_W-1:0]    sat_next;
    logic signed [OUT_W-1:0]    clip_hi;
    logic signed [OUT_W-1:0]    clip_val;

    assign take    = (state_reg == S_IDLE) && !op_empty;
    assign op_pop  = take;
    assign coef_we = take && (op.kind == OP_COEF);
    assign buf_we  = take && (op.kind == OP_SAMPLE || op.kind == OP_RENDER);
    assign issuing = (state_reg == S_MAC) && (k_reg < cfg.comp_count);
    assign last_ch = ({1'b0, ch_reg} + CNT_W'(1)) == cfg.chan_count;

    assign coef_wa = CADDR_W'(32'(op.spk) * MAX_COMPONENTS + 32'(op.comp));
    assign coef_ra = row_base_reg + CADDR_W'(k_reg);
    assign buf_wa  = op.comp[BADDR_W-1:0];
    assign buf_ra  = k_reg[BADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_wa] <= op.data;
        if (issuing)
            coef_rd_reg <= coef_mem[coef_ra];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa] <= op.data;
        if (issuing)
            buf_rd_reg <= buf_mem[buf_ra];
    end

    assign acc_biased = acc_reg + ACC_BIAS;

    always_comb
    begin
        if (rnd_reg > RND_MAX)
            sat_next = OUT_MAX;
        else if (rnd_reg < RND_MIN)
            sat_next = OUT_MIN;
        else
            sat_next = rnd_reg[OUT_W-1:0];
    end

    always_comb
    begin
        clip_hi  = (cfg.clip_en && sat_reg > cfg.clip_upper) ? cfg.clip_upper : sat_reg;
        clip_val = (cfg.clip_en && clip_hi < cfg.clip_lower) ? cfg.clip_lower : clip_hi;
    end

    assign res_push    = (state_reg == S_EMIT) && !res_full;
    assign res.channel = ch_reg;
    assign res.sample  = clip_val;
    assign res.clipped = cfg.clip_en && (clip_val != sat_reg);
    assign res.last    = last_ch;

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            prod_reg <= coef_rd_reg * buf_rd_reg;
        if (state_reg == S_IDLE || state_reg == S_EMIT)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (state_reg == S_ROUND)
            rnd_reg <= acc_biased[ACC_W-1:RND_SHIFT];
        if (state_reg == S_SAT)
            sat_reg <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            ch_reg         <= '0;
            row_base_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= issuing;
            prod_valid_reg <= rd_valid_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (take && op.kind == OP_RENDER)
                    begin
                        k_reg        <= '0;
                        ch_reg       <= '0;
                        row_base_reg <= '0;
                        state_reg    <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (issuing)
                        k_reg <= k_reg + CNT_W'(1);
                    else if (!rd_valid_reg && !prod_valid_reg)
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                    state_reg <= S_SAT;
                S_SAT:
                    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (!res_full)
                    begin
                        if (last_ch)
                            state_reg <= S_IDLE;
                        else
                        begin
                            ch_reg       <= ch_reg + IDX_W'(1);
                            row_base_reg <= row_base_reg + CADDR_W'(MAX_COMPONENTS);
                            k_reg        <= '0;
                            state_reg    <= S_MAC;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
